// ----- hdl/kvp_pkg.sv -----
// ----------------------------------------------------------------------------
// kvp_pkg
// Shared types, codes and literal tables of the text get-reply parser.
// ----------------------------------------------------------------------------
`default_nettype none

package kvp_pkg;

   localparam int KEY_BYTES_DEFAULT = 128;
   localparam int QUEUE_DEPTH       = 2;
   localparam int QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] KIND_KEY    = 3'd0;
   localparam logic [2:0] KIND_HEADER = 3'd1;
   localparam logic [2:0] KIND_DATA   = 3'd2;
   localparam logic [2:0] KIND_END    = 3'd3;
   localparam logic [2:0] KIND_ERROR  = 3'd4;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_PROTO  = 2'd1;
   localparam logic [1:0] ERR_KEYBIG = 2'd2;

   localparam logic CSR_EXPECT_CAS  = 1'b0;
   localparam logic CSR_VALUE_COUNT = 1'b1;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   localparam logic [2:0] LIT_VALUE_LAST = 3'd5;
   localparam logic [2:0] LIT_END_LAST   = 3'd4;
   localparam logic [2:0] LIT_CRLF_LAST  = 3'd1;

   typedef enum logic [3:0] {
      PH_START,
      PH_PREFIX,
      PH_KEY,
      PH_FLAGS,
      PH_SIZE,
      PH_CAS,
      PH_LF,
      PH_DATA,
      PH_TRAIL
   } phase_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       is_digit;
      logic [3:0] digit_value;
      logic       is_space;
      logic       is_cr;
      logic       is_lf;
   } rx_class_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  byte_value;
      logic [31:0] flags_value;
      logic [30:0] data_size;
      logic [63:0] cas_unique;
      logic [1:0]  error_code;
   } result_type;

   function automatic logic [7:0] lit_value_byte(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0: c = 8'h56;
         3'd1: c = 8'h41;
         3'd2: c = 8'h4C;
         3'd3: c = 8'h55;
         3'd4: c = 8'h45;
         3'd5: c = CHAR_SPACE;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] lit_end_byte(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0: c = 8'h45;
         3'd1: c = 8'h4E;
         3'd2: c = 8'h44;
         3'd3: c = CHAR_CR;
         3'd4: c = CHAR_LF;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] lit_crlf_byte(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0: c = CHAR_CR;
         3'd1: c = CHAR_LF;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/kvp_front.sv -----
// ----------------------------------------------------------------------------
// kvp_front
// Classifies each received byte and holds it in a short queue for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module kvp_front
   import kvp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output logic              full,
   input  wire logic [7:0]   rx_byte,
   input  wire logic         pop,
   output logic              empty,
   output rx_class_type      head
);

   rx_class_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]       count_ff, count_in;
   rx_class_type                 cls;
   logic                         do_push, do_pop;

   always_comb begin
      cls.byte_value  = rx_byte;
      cls.is_digit    = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
      cls.digit_value = 4'(rx_byte - CHAR_ZERO);
      cls.is_space    = (rx_byte == CHAR_SPACE);
      cls.is_cr       = (rx_byte == CHAR_CR);
      cls.is_lf       = (rx_byte == CHAR_LF);
   end

   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? QUEUE_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? QUEUE_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = QUEUE_CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QUEUE_CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/kvp_engine.sv -----
// ----------------------------------------------------------------------------
// kvp_engine
// Parser FSM: one classified byte per cycle on advance, at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module kvp_engine
   import kvp_pkg::*;
#(
   parameter int KEY_BYTES = KEY_BYTES_DEFAULT
)(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire rx_class_type  in_byte,
   input  wire logic          expect_cas,
   input  wire logic [15:0]   value_count,
   output logic               res_valid,
   output result_type         res
);

   localparam int KeyW = $clog2(KEY_BYTES);
   localparam logic [KeyW-1:0] KeyLast = KeyW'(KEY_BYTES - 1);

   phase_type        phase_ff, phase_in;
   logic [2:0]       lit_ff, lit_in;
   logic [KeyW-1:0]  key_len_ff, key_len_in;
   logic [31:0]      flags_ff, flags_in;
   logic [30:0]      size_ff, size_in;
   logic [63:0]      cas_ff, cas_in;
   logic [30:0]      remain_ff, remain_in;
   logic [15:0]      records_ff, records_in;

   phase_type        ph;
   logic [15:0]      rec;
   logic [35:0]      flags_x10;
   logic [34:0]      size_x10;
   logic [63:0]      cas_x10;
   logic [30:0]      remain_dec;
   logic             fail;
   logic [1:0]       fail_code;
   logic [7:0]       b;

   assign b = in_byte.byte_value;

   always_comb begin
      flags_x10 = ({4'b0, flags_ff} << 3) + ({4'b0, flags_ff} << 1)
                + {32'b0, in_byte.digit_value};
      size_x10  = ({4'b0, size_ff} << 3) + ({4'b0, size_ff} << 1)
                + {31'b0, in_byte.digit_value};
      cas_x10   = (cas_ff << 3) + (cas_ff << 1) + {60'b0, in_byte.digit_value};
      remain_dec = (remain_ff != '0) ? 31'(remain_ff - 1'b1) : remain_ff;
   end

   always_comb begin
      ph  = phase_ff;
      rec = records_ff;
      if (phase_ff == PH_START) begin
         ph  = PH_PREFIX;
         rec = value_count;
      end
      phase_in   = ph;
      records_in = rec;
      lit_in     = lit_ff;
      key_len_in = key_len_ff;
      flags_in   = flags_ff;
      size_in    = size_ff;
      cas_in     = cas_ff;
      remain_in  = remain_ff;
      fail       = 1'b0;
      fail_code  = ERR_PROTO;
      res_valid  = 1'b0;
      res        = '0;

      unique case (ph)
         PH_PREFIX: begin
            if (rec != '0) begin
               if (lit_ff > LIT_VALUE_LAST || b != lit_value_byte(lit_ff)) begin
                  fail = 1'b1;
               end else if (lit_ff == LIT_VALUE_LAST) begin
                  lit_in     = '0;
                  key_len_in = '0;
                  flags_in   = '0;
                  size_in    = '0;
                  cas_in     = '0;
                  phase_in   = PH_KEY;
               end else begin
                  lit_in = 3'(lit_ff + 1'b1);
               end
            end else begin
               if (lit_ff > LIT_END_LAST || b != lit_end_byte(lit_ff)) begin
                  fail = 1'b1;
               end else if (lit_ff == LIT_END_LAST) begin
                  phase_in   = PH_START;
                  records_in = '0;
                  lit_in     = '0;
                  key_len_in = '0;
                  flags_in   = '0;
                  size_in    = '0;
                  cas_in     = '0;
                  remain_in  = '0;
                  res_valid  = 1'b1;
                  res.kind   = KIND_END;
               end else begin
                  lit_in = 3'(lit_ff + 1'b1);
               end
            end
         end
         PH_KEY: begin
            if (in_byte.is_space) begin
               phase_in = PH_FLAGS;
            end else if (key_len_ff >= KeyLast) begin
               fail      = 1'b1;
               fail_code = ERR_KEYBIG;
            end else begin
               key_len_in     = KeyW'(key_len_ff + 1'b1);
               res_valid      = 1'b1;
               res.kind       = KIND_KEY;
               res.byte_value = b;
            end
         end
         PH_FLAGS: begin
            if (in_byte.is_digit) begin
               if (flags_x10[35:32] != '0) begin
                  fail = 1'b1;
               end else begin
                  flags_in = flags_x10[31:0];
               end
            end else if (in_byte.is_space) begin
               phase_in = PH_SIZE;
            end else begin
               fail = 1'b1;
            end
         end
         PH_SIZE: begin
            if (in_byte.is_digit) begin
               if (size_x10[34:31] != '0) begin
                  fail = 1'b1;
               end else begin
                  size_in = size_x10[30:0];
               end
            end else if (in_byte.is_space && expect_cas) begin
               phase_in = PH_CAS;
            end else if (in_byte.is_cr) begin
               phase_in = PH_LF;
            end else begin
               fail = 1'b1;
            end
         end
         PH_CAS: begin
            if (in_byte.is_digit) begin
               cas_in = cas_x10;
            end else if (in_byte.is_cr) begin
               phase_in = PH_LF;
            end else begin
               fail = 1'b1;
            end
         end
         PH_LF: begin
            if (!in_byte.is_lf) begin
               fail = 1'b1;
            end else begin
               res_valid       = 1'b1;
               res.kind        = KIND_HEADER;
               res.flags_value = flags_ff;
               res.data_size   = size_ff;
               res.cas_unique  = cas_ff;
               remain_in       = size_ff;
               lit_in          = '0;
               phase_in        = (size_ff != '0) ? PH_DATA : PH_TRAIL;
            end
         end
         PH_DATA: begin
            remain_in = remain_dec;
            if (remain_dec == '0) begin
               lit_in   = '0;
               phase_in = PH_TRAIL;
            end
            res_valid      = 1'b1;
            res.kind       = KIND_DATA;
            res.byte_value = b;
         end
         PH_TRAIL: begin
            if (lit_ff > LIT_CRLF_LAST || b != lit_crlf_byte(lit_ff)) begin
               fail = 1'b1;
            end else if (lit_ff == LIT_CRLF_LAST) begin
               lit_in     = '0;
               records_in = (rec != '0) ? 16'(rec - 1'b1) : rec;
               phase_in   = PH_PREFIX;
            end else begin
               lit_in = 3'(lit_ff + 1'b1);
            end
         end
         default: begin
            phase_in = PH_PREFIX;
         end
      endcase

      if (fail) begin
         phase_in       = PH_START;
         records_in     = '0;
         lit_in         = '0;
         key_len_in     = '0;
         flags_in       = '0;
         size_in        = '0;
         cas_in         = '0;
         remain_in      = '0;
         res_valid      = 1'b1;
         res            = '0;
         res.kind       = KIND_ERROR;
         res.error_code = fail_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         lit_ff     <= '0;
         key_len_ff <= '0;
         flags_ff   <= '0;
         size_ff    <= '0;
         cas_ff     <= '0;
         remain_ff  <= '0;
         records_ff <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         lit_ff     <= lit_in;
         key_len_ff <= key_len_in;
         flags_ff   <= flags_in;
         size_ff    <= size_in;
         cas_ff     <= cas_in;
         remain_ff  <= remain_in;
         records_ff <= records_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/kvp_rsp_queue.sv -----
// ----------------------------------------------------------------------------
// kvp_rsp_queue
// Short result queue between the parser engine and the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module kvp_rsp_queue
   import kvp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire result_type  push_data,
   output logic             full,
   input  wire logic        pop,
   output logic             empty,
   output result_type       head
);

   result_type                   entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]       count_ff, count_in;
   logic                         do_push, do_pop;

   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? QUEUE_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? QUEUE_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = QUEUE_CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QUEUE_CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/kv_text_value_reply_parser.sv -----
// ----------------------------------------------------------------------------
// kv_text_value_reply_parser
// Parses a text get reply one received byte at a time.
//
// Request side: a queue port. Push rx bytes with req_push while req_full is
// low; each transfer carries one reply byte.
// Response side: a queue port. While rsp_empty is low the oldest result is
// on the rsp_ ports; rsp_pop takes it. Results are key bytes, a header
// (flags, size, cas), data bytes, an end marker or an error code.
// CSR port: csr_we writes csr_wdata to the register selected by csr_index
// (0 expect_cas, 1 value_count). Write only while the parser is idle.
// Throughput: one byte per cycle unless stalled, set by the combinational
// engine step (decimal digits accumulate through a shift-add times ten).
// Path: the transfer edge writes the front queue; the engine steps on a later
// edge with room in the result queue, and that edge writes the result there.
// Stall: when the receiver holds off, the result queue fills, the engine
// stops, the front queue fills and req_full rises; nothing is dropped.
// Reset: queues empty, registers zero, the parser waits for a new reply.
// ----------------------------------------------------------------------------
`default_nettype none

module kv_text_value_reply_parser
   import kvp_pkg::*;
#(
   parameter int KEY_BYTES = KEY_BYTES_DEFAULT
)(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_push,
   output logic               req_full,
   input  wire logic [7:0]    req_rx_byte,
   output logic               rsp_empty,
   input  wire logic          rsp_pop,
   output logic [2:0]         rsp_kind,
   output logic [7:0]         rsp_byte_value,
   output logic [31:0]        rsp_flags_value,
   output logic [30:0]        rsp_data_size,
   output logic [63:0]        rsp_cas_unique,
   output logic [1:0]         rsp_error_code,
   input  wire logic          csr_we,
   input  wire logic          csr_index,
   input  wire logic [15:0]   csr_wdata
);

   logic           expect_cas_ff;
   logic [15:0]    value_count_ff;
   rx_class_type   front_head;
   logic           front_empty;
   logic           advance;
   logic           res_valid;
   result_type     res;
   logic           rq_full;
   result_type     rq_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_cas_ff  <= 1'b0;
         value_count_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_EXPECT_CAS:  expect_cas_ff  <= csr_wdata[0];
            CSR_VALUE_COUNT: value_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign advance = !front_empty && !rq_full;

   kvp_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .full    (req_full),
      .rx_byte (req_rx_byte),
      .pop     (advance),
      .empty   (front_empty),
      .head    (front_head)
   );

   kvp_engine #(
      .KEY_BYTES (KEY_BYTES)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_byte     (front_head),
      .expect_cas  (expect_cas_ff),
      .value_count (value_count_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   kvp_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (advance && res_valid),
      .push_data (res),
      .full      (rq_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (rq_head)
   );

   assign rsp_kind        = rq_head.kind;
   assign rsp_byte_value  = rq_head.byte_value;
   assign rsp_flags_value = rq_head.flags_value;
   assign rsp_data_size   = rq_head.data_size;
   assign rsp_cas_unique  = rq_head.cas_unique;
   assign rsp_error_code  = rq_head.error_code;

endmodule

`default_nettype wire

// ----- sim/kv_text_value_reply_parser_tb.sv -----
// ----------------------------------------------------------------------------
// kv_text_value_reply_parser_tb
// Feeds text get replies into the parser one byte per transfer and checks
// every result against a cycle-free prediction of the parse. A directed part
// covers literal faults, empty fields, number limits, cas wrap and the key
// length limit; random replies follow, mostly well formed with random keys,
// numbers and data, the rest cut short or pure noise. Both queue ports idle
// and stall at random, and the registers change between groups of replies.
// ----------------------------------------------------------------------------
module kv_text_value_reply_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kvp_pkg::*;

   localparam int KEY_MAX = KEY_BYTES_DEFAULT - 1;

   typedef enum {REPLY_CLEAN, REPLY_CUT, REPLY_NOISE} reply_form_type;

   class reply_scoreboard;
      bit          cas_on;
      logic [15:0] record_total;
      phase_type   ph;
      int          lit_idx;
      int          key_len;
      logic [31:0] flags_acc;
      logic [30:0] size_acc;
      logic [63:0] cas_acc;
      logic [30:0] data_left;
      logic [15:0] records_left;
      result_type  pending_results[$];
      int          failures;

      function new();
         cas_on = 1'b0;
         record_total = '0;
         failures = 0;
         clear_state();
      endfunction

      function void clear_state();
         ph = PH_START;
         lit_idx = 0;
         key_len = 0;
         flags_acc = '0;
         size_acc = '0;
         cas_acc = '0;
         data_left = '0;
         records_left = '0;
      endfunction

      function void set_reg(logic idx, logic [15:0] val);
         if (idx == CSR_EXPECT_CAS) begin
            cas_on = val[0];
         end else begin
            record_total = val;
         end
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function void note_rx_byte(logic [7:0] b);
         logic [7:0]  value_line [6] = '{"V", "A", "L", "U", "E", CHAR_SPACE};
         logic [7:0]  end_line [5] = '{"E", "N", "D", CHAR_CR, CHAR_LF};
         result_type  r;
         logic [35:0] acc;
         logic [7:0]  d;
         logic [1:0]  code;
         bit          is_dig;
         bit          give;
         bit          fault;
         r = '0;
         give = 1'b0;
         fault = 1'b0;
         code = ERR_PROTO;
         is_dig = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
         d = b - CHAR_ZERO;
         acc = '0;
         if (ph == PH_START) begin
            clear_state();
            records_left = record_total;
            ph = PH_PREFIX;
         end
         case (ph)
            PH_PREFIX: begin
               if (records_left != 0) begin
                  if (b != value_line[lit_idx]) begin
                     fault = 1'b1;
                  end else if (lit_idx == 5) begin
                     lit_idx = 0;
                     key_len = 0;
                     flags_acc = '0;
                     size_acc = '0;
                     cas_acc = '0;
                     ph = PH_KEY;
                  end else begin
                     lit_idx++;
                  end
               end else if (b != end_line[lit_idx]) begin
                  fault = 1'b1;
               end else if (lit_idx == 4) begin
                  clear_state();
                  r.kind = KIND_END;
                  give = 1'b1;
               end else begin
                  lit_idx++;
               end
            end
            PH_KEY: begin
               if (b == CHAR_SPACE) begin
                  ph = PH_FLAGS;
               end else if (key_len >= KEY_MAX) begin
                  fault = 1'b1;
                  code = ERR_KEYBIG;
               end else begin
                  key_len++;
                  r.kind = KIND_KEY;
                  r.byte_value = b;
                  give = 1'b1;
               end
            end
            PH_FLAGS: begin
               if (is_dig) begin
                  acc = 36'(flags_acc) * 36'd10 + 36'(d);
                  if (acc > 36'hFFFF_FFFF) begin
                     fault = 1'b1;
                  end else begin
                     flags_acc = acc[31:0];
                  end
               end else if (b == CHAR_SPACE) begin
                  ph = PH_SIZE;
               end else begin
                  fault = 1'b1;
               end
            end
            PH_SIZE: begin
               if (is_dig) begin
                  acc = 36'(size_acc) * 36'd10 + 36'(d);
                  if (acc > 36'h7FFF_FFFF) begin
                     fault = 1'b1;
                  end else begin
                     size_acc = acc[30:0];
                  end
               end else if (b == CHAR_SPACE && cas_on) begin
                  ph = PH_CAS;
               end else if (b == CHAR_CR) begin
                  ph = PH_LF;
               end else begin
                  fault = 1'b1;
               end
            end
            PH_CAS: begin
               if (is_dig) begin
                  cas_acc = cas_acc * 64'd10 + 64'(d);
               end else if (b == CHAR_CR) begin
                  ph = PH_LF;
               end else begin
                  fault = 1'b1;
               end
            end
            PH_LF: begin
               if (b != CHAR_LF) begin
                  fault = 1'b1;
               end else begin
                  r.kind = KIND_HEADER;
                  r.flags_value = flags_acc;
                  r.data_size = size_acc;
                  r.cas_unique = cas_acc;
                  give = 1'b1;
                  data_left = size_acc;
                  lit_idx = 0;
                  ph = (size_acc != 0) ? PH_DATA : PH_TRAIL;
               end
            end
            PH_DATA: begin
               if (data_left != 0) data_left--;
               if (data_left == 0) begin
                  lit_idx = 0;
                  ph = PH_TRAIL;
               end
               r.kind = KIND_DATA;
               r.byte_value = b;
               give = 1'b1;
            end
            PH_TRAIL: begin
               if (b != ((lit_idx == 0) ? CHAR_CR : CHAR_LF)) begin
                  fault = 1'b1;
               end else if (lit_idx == 1) begin
                  lit_idx = 0;
                  if (records_left != 0) records_left--;
                  ph = PH_PREFIX;
               end else begin
                  lit_idx++;
               end
            end
            default: ;
         endcase
         if (fault) begin
            clear_state();
            r = '0;
            r.kind = KIND_ERROR;
            r.error_code = code;
            give = 1'b1;
         end
         if (give) pending_results.push_back(r);
      endfunction

      function void compare(string field, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            failures++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            $error("result with nothing expected: kind %0d", got.kind);
            failures++;
            return;
         end
         want = pending_results.pop_front();
         compare("kind", want.kind, got.kind);
         compare("byte_value", want.byte_value, got.byte_value);
         compare("flags_value", want.flags_value, got.flags_value);
         compare("data_size", want.data_size, got.data_size);
         compare("cas_unique", want.cas_unique, got.cas_unique);
         compare("error_code", want.error_code, got.error_code);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_rx_byte;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_byte_value;
   logic [31:0] rsp_flags_value;
   logic [30:0] rsp_data_size;
   logic [63:0] rsp_cas_unique;
   logic [1:0]  rsp_error_code;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;
   result_type  rsp_now;

   reply_scoreboard sb = new();
   logic [7:0]      reply_bytes[$];
   bit              steady_feed;
   bit              cur_cas;
   logic [15:0]     cur_count;
   int              rx_sent;

   assign rsp_now = {rsp_kind, rsp_byte_value, rsp_flags_value, rsp_data_size,
                     rsp_cas_unique, rsp_error_code};

   kv_text_value_reply_parser dut (
      .clock,
      .reset,
      .req_push,
      .req_full,
      .req_rx_byte,
      .rsp_empty,
      .rsp_pop,
      .rsp_kind,
      .rsp_byte_value,
      .rsp_flags_value,
      .rsp_data_size,
      .rsp_cas_unique,
      .rsp_error_code,
      .csr_we,
      .csr_index,
      .csr_wdata
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int lead_zeros();
      return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
   endfunction

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) reply_bytes.push_back(s[i]);
   endfunction

   function automatic void put_crlf();
      reply_bytes.push_back(CHAR_CR);
      reply_bytes.push_back(CHAR_LF);
   endfunction

   function automatic void put_end();
      put_text("END");
      put_crlf();
   endfunction

   function automatic void put_dec(logic [63:0] v, int zeros);
      logic [7:0] digits[$];
      repeat (zeros) reply_bytes.push_back(CHAR_ZERO);
      do begin
         digits.push_front(CHAR_ZERO + 8'(v % 10));
         v = v / 10;
      end while (v != 0);
      foreach (digits[i]) reply_bytes.push_back(digits[i]);
   endfunction

   function automatic void put_record();
      int         klen;
      int         size;
      int         roll;
      logic [7:0] b;
      put_text("VALUE ");
      roll = $urandom_range(0, 19);
      klen = (roll == 0) ? 0 : (roll == 1) ? KEY_MAX : $urandom_range(1, 6);
      repeat (klen) begin
         do b = 8'($urandom_range(0, 255)); while (b == CHAR_SPACE);
         reply_bytes.push_back(b);
      end
      reply_bytes.push_back(CHAR_SPACE);
      case ($urandom_range(0, 5))
         0: ;
         1: put_dec(64'hFFFF_FFFF, lead_zeros());
         2: put_dec(64'($urandom()), lead_zeros());
         default: put_dec(64'($urandom_range(0, 999)), lead_zeros());
      endcase
      reply_bytes.push_back(CHAR_SPACE);
      size = $urandom_range(0, 8);
      if (size != 0 || $urandom_range(0, 3) != 0) put_dec(64'(size), lead_zeros());
      if (cur_cas && $urandom_range(0, 3) != 0) begin
         reply_bytes.push_back(CHAR_SPACE);
         case ($urandom_range(0, 3))
            0: ;
            1: repeat ($urandom_range(20, 26))
                  reply_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            default: put_dec({$urandom(), $urandom()}, 0);
         endcase
      end
      put_crlf();
      repeat (size) reply_bytes.push_back(8'($urandom_range(0, 255)));
      put_crlf();
   endfunction

   function automatic void build_reply(reply_form_type shape);
      int recs;
      int cut;
      recs = (cur_count > 3) ? 3 : int'(cur_count);
      repeat (recs) put_record();
      put_end();
      if (shape == REPLY_NOISE) begin
         reply_bytes.delete();
         repeat ($urandom_range(1, 5)) reply_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (shape == REPLY_CUT || cur_count > 3) begin
         cut = $urandom_range(0, reply_bytes.size() - 1);
         while (reply_bytes.size() > cut) void'(reply_bytes.pop_back());
         reply_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   task automatic push_byte(logic [7:0] b);
      int gap;
      gap = steady_feed ? 0 : pick_gap();
      if (gap != 0) begin
         @(negedge clock) req_push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_push <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_rx_byte(b);
      rx_sent++;
   endtask

   task automatic ship();
      foreach (reply_bytes[i]) push_byte(reply_bytes[i]);
      reply_bytes.delete();
   endtask

   // drive the parser back to the start of a reply
   task automatic settle_parser();
      logic [7:0] b;
      while (sb.ph != PH_START) begin
         case (sb.ph)
            PH_KEY: b = CHAR_SPACE;
            PH_DATA: b = 8'($urandom_range(0, 255));
            default: b = 8'h00;
         endcase
         push_byte(b);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock) req_push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock) csr_we <= 1'b0;
      sb.set_reg(idx, val);
      if (idx == CSR_EXPECT_CAS) begin
         cur_cas = val[0];
      end else begin
         cur_count = val;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) sb.check_result(rsp_now);
   end

   initial begin : pop_drive
      int hold;
      int stall;
      rsp_pop = 1'b0;
      forever begin
         hold = $urandom_range(1, 30);
         stall = ($urandom_range(0, 4) == 0) ? 0 : pick_gap();
         @(negedge clock) rsp_pop <= 1'b1;
         repeat (hold - 1) @(negedge clock);
         if (stall != 0) begin
            @(negedge clock) rsp_pop <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      int             random_start;
      reply_form_type shape;
      int             roll;
      reset = 1'b1;
      req_push = 1'b0;
      req_rx_byte = '0;
      csr_we = 1'b0;
      csr_index = CSR_EXPECT_CAS;
      csr_wdata = '0;
      steady_feed = 1'b0;
      cur_cas = 1'b0;
      cur_count = '0;
      rx_sent = 0;
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      put_end();
      put_text("ENX");
      ship();
      wait_idle();

      write_reg(CSR_EXPECT_CAS, 16'd0);
      write_reg(CSR_VALUE_COUNT, 16'd1);
      put_text("VALUE k 4294967295 0");
      put_crlf();
      put_crlf();
      put_end();
      put_text("VALUE   ");
      put_crlf();
      put_crlf();
      put_end();
      put_text("VALUE a 4294967296");
      put_text("VALUE a 1 2147483648");
      put_text("VALUE a 1 2147483647x");
      put_text("VALUE a 1 2 ");
      put_text("VALUX");
      put_text("VALUE ");
      reply_bytes.push_back(8'h00);
      reply_bytes.push_back(8'hFF);
      put_text(" 0 2");
      put_crlf();
      reply_bytes.push_back(8'hFF);
      reply_bytes.push_back(8'h00);
      put_crlf();
      put_end();
      put_text("VALUE ");
      repeat (KEY_MAX) put_text("k");
      put_text(" 0 0");
      put_crlf();
      put_crlf();
      put_end();
      put_text("VALUE ");
      repeat (KEY_MAX + 1) put_text("k");
      ship();
      wait_idle();

      write_reg(CSR_EXPECT_CAS, 16'hFFFF);
      write_reg(CSR_VALUE_COUNT, 16'd2);
      put_text("VALUE ab 3 2 99999999999999999999999");
      put_crlf();
      put_text("xy");
      put_crlf();
      put_text("VALUE c 0 0 ");
      put_crlf();
      put_crlf();
      put_end();
      ship();
      wait_idle();

      write_reg(CSR_VALUE_COUNT, 16'hFFFF);
      put_end();
      ship();

      random_start = rx_sent;
      while (rx_sent - random_start < 400) begin
         wait_idle();
         write_reg(CSR_EXPECT_CAS, {15'($urandom()), 1'($urandom_range(0, 1))});
         roll = $urandom_range(0, 9);
         case (roll)
            0, 1: write_reg(CSR_VALUE_COUNT, 16'd0);
            2: write_reg(CSR_VALUE_COUNT, 16'hFFFF);
            3: write_reg(CSR_VALUE_COUNT, 16'($urandom()));
            4, 5: write_reg(CSR_VALUE_COUNT, 16'($urandom_range(2, 3)));
            default: write_reg(CSR_VALUE_COUNT, 16'd1);
         endcase
         steady_feed = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 4)) begin
            roll = $urandom_range(0, 9);
            shape = (roll < 7) ? REPLY_CLEAN : (roll < 9) ? REPLY_CUT : REPLY_NOISE;
            build_reply(shape);
            ship();
            settle_parser();
         end
      end
      wait_idle();

      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
